>>> sv/masked_mean_squared_distance_macros.svh
// Assertion helpers for the file that carries checks, the top-level module.
`ifndef MASKED_MEAN_SQUARED_DISTANCE_MACROS_SVH
`define MASKED_MEAN_SQUARED_DISTANCE_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define MMSD_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("mmsd check failed");

// Consequent must hold in the cycle after the antecedent.
`define MMSD_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("mmsd check failed");

`endif

>>> sv/mmsd_pkg.sv
package mmsd_pkg;

  // Fixed field widths of the item formats.
  localparam int COORD_W = 20;
  localparam int SUM_W   = 56;
  localparam int MEAN_W  = 44;
  localparam int COUNT_W = 13;

  // One atom as it arrives.
  typedef struct packed {
    logic               active;
    logic               heavy;
    logic [COORD_W-1:0] ref_x;
    logic [COORD_W-1:0] ref_y;
    logic [COORD_W-1:0] ref_z;
    logic [COORD_W-1:0] conf_x;
    logic [COORD_W-1:0] conf_y;
    logic [COORD_W-1:0] conf_z;
    logic               last_atom;
  } atom_t;

  // One result per molecule.
  typedef struct packed {
    logic [MEAN_W-1:0]  mean_sq_distance;
    logic [COUNT_W-1:0] atoms_counted;
    logic               count_overflow;
  } result_t;

  // Classification flags that travel with each atom through the queue.
  typedef struct packed {
    logic qualify;
    logic last;
  } atom_ctl_t;

endpackage

>>> sv/mmsd_front.sv
module mmsd_front import mmsd_pkg::*; #(
  parameter int COORD_BITS = 20
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                atom_valid,
  output logic                atom_stall,
  input  atom_t               atom,
  input  logic                q_full,
  output logic                push,
  output atom_ctl_t           push_ctl,
  output logic [COORD_BITS:0] push_dx,
  output logic [COORD_BITS:0] push_dy,
  output logic [COORD_BITS:0] push_dz
);

  localparam int CB = COORD_BITS;

  logic                f_valid;
  atom_ctl_t           f_ctl;
  logic [CB:0]         f_dx;
  logic [CB:0]         f_dy;
  logic [CB:0]         f_dz;
  logic [CB:0]         mag_x;
  logic [CB:0]         mag_y;
  logic [CB:0]         mag_z;

  // Absolute difference of two coordinates, each read as CB-bit two's complement.
  function automatic logic [CB:0] abs_diff(logic [COORD_W-1:0] r, logic [COORD_W-1:0] c);
    logic [CB-1:0]      rv;
    logic [CB-1:0]      cv;
    logic signed [CB:0] d;
    rv = CB'(r);
    cv = CB'(c);
    d  = signed'({cv[CB-1], cv}) - signed'({rv[CB-1], rv});
    return d[CB] ? (CB+1)'(-d) : (CB+1)'(d);
  endfunction

  always_comb begin
    mag_x = abs_diff(atom.ref_x, atom.conf_x);
    mag_y = abs_diff(atom.ref_y, atom.conf_y);
    mag_z = abs_diff(atom.ref_z, atom.conf_z);
  end

  // The front register holds one item until the queue has room.
  assign atom_stall = f_valid && q_full;
  assign push       = f_valid && !q_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      f_valid <= 1'b0;
    end else if (!atom_stall) begin
      f_valid <= atom_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!atom_stall && atom_valid) begin
      f_ctl.qualify <= atom.active && atom.heavy;
      f_ctl.last    <= atom.last_atom;
      f_dx          <= mag_x;
      f_dy          <= mag_y;
      f_dz          <= mag_z;
    end
  end

  assign push_ctl = f_ctl;
  assign push_dx  = f_dx;
  assign push_dy  = f_dy;
  assign push_dz  = f_dz;

endmodule

>>> sv/mmsd_queue.sv
module mmsd_queue #(
  parameter int WIDTH = 65,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] pop_data,
  output logic             nonempty
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slots [DEPTH];
  logic [AW-1:0]    wptr;
  logic [AW-1:0]    rptr;
  logic [CW-1:0]    level;

  assign full     = (level == CW'(DEPTH));
  assign nonempty = (level != '0);
  assign pop_data = slots[rptr];

  // Pointer and fill level bookkeeping.
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      level <= '0;
    end else begin
      if (push) begin
        wptr <= (wptr == AW'(DEPTH - 1)) ? '0 : wptr + 1'b1;
      end
      if (pop) begin
        rptr <= (rptr == AW'(DEPTH - 1)) ? '0 : rptr + 1'b1;
      end
      if (push && !pop) begin
        level <= level + 1'b1;
      end else if (pop && !push) begin
        level <= level - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wptr] <= push_data;
    end
  end

endmodule

>>> sv/mmsd_back.sv
module mmsd_back import mmsd_pkg::*; #(
  parameter int COORD_BITS = 20,
  parameter int MAX_ATOMS  = 4096,
  parameter int CNT_W      = 13
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                q_valid,
  output logic                pop,
  input  atom_ctl_t           pop_ctl,
  input  logic [COORD_BITS:0] pop_dx,
  input  logic [COORD_BITS:0] pop_dy,
  input  logic [COORD_BITS:0] pop_dz,
  input  logic                div_ready,
  output logic                div_start,
  output logic [SUM_W-1:0]    div_sum,
  output logic [CNT_W-1:0]    div_count,
  output logic                div_ovf
);

  localparam int DW   = COORD_BITS + 1;
  localparam int SQ_W = 2 * DW;
  localparam int D2_W = SQ_W + 2;

  logic              s1_valid;
  atom_ctl_t         s1_ctl;
  logic [SQ_W-1:0]   sq_x;
  logic [SQ_W-1:0]   sq_y;
  logic [SQ_W-1:0]   sq_z;
  logic              s1_take;
  logic              s1_load;

  logic [SUM_W-1:0]  acc;
  logic [CNT_W-1:0]  cnt;
  logic              ovf;
  logic [SUM_W-1:0]  acc_next;
  logic [CNT_W-1:0]  cnt_next;
  logic              ovf_next;
  logic [D2_W-1:0]   d2;
  logic [SUM_W:0]    sum_add;

  // A last atom leaves the square stage only when the divider can take the totals.
  assign s1_take = s1_valid && (!s1_ctl.last || div_ready);
  assign s1_load = !s1_valid || s1_take;
  assign pop     = q_valid && s1_load;

  // Square stage: one multiplier per axis.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_load) begin
      s1_valid <= q_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      s1_ctl <= pop_ctl;
      sq_x   <= pop_dx * pop_dx;
      sq_y   <= pop_dy * pop_dy;
      sq_z   <= pop_dz * pop_dz;
    end
  end

  // Saturating accumulate, with the count held at its limit once full.
  always_comb begin
    d2       = D2_W'(sq_x) + D2_W'(sq_y) + D2_W'(sq_z);
    sum_add  = {1'b0, acc} + (SUM_W+1)'(d2);
    acc_next = acc;
    cnt_next = cnt;
    ovf_next = ovf;
    if (s1_ctl.qualify) begin
      if (cnt >= CNT_W'(MAX_ATOMS)) begin
        ovf_next = 1'b1;
      end else begin
        acc_next = sum_add[SUM_W] ? '1 : sum_add[SUM_W-1:0];
        cnt_next = cnt + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc <= '0;
      cnt <= '0;
      ovf <= 1'b0;
    end else if (s1_take) begin
      if (s1_ctl.last) begin
        acc <= '0;
        cnt <= '0;
        ovf <= 1'b0;
      end else begin
        acc <= acc_next;
        cnt <= cnt_next;
        ovf <= ovf_next;
      end
    end
  end

  // Totals of the molecule go to the divider together with its last atom.
  assign div_start = s1_take && s1_ctl.last;
  assign div_sum   = acc_next;
  assign div_count = cnt_next;
  assign div_ovf   = ovf_next;

endmodule

>>> sv/mmsd_div.sv
module mmsd_div import mmsd_pkg::*; #(
  parameter int CNT_W = 13
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [SUM_W-1:0] sum,
  input  logic [CNT_W-1:0] count,
  input  logic             ovf,
  output logic             ready,
  output logic             result_valid,
  input  logic             result_stall,
  output result_t          result
);

  localparam int STEP_W = $clog2(SUM_W + 1);

  typedef enum logic [2:0] {
    DIV_IDLE = 3'b001,
    DIV_RUN  = 3'b010,
    DIV_DONE = 3'b100
  } div_state_t;

  div_state_t        state;
  logic [SUM_W-1:0]  quo;
  logic [CNT_W-1:0]  rem;
  logic [CNT_W-1:0]  divisor;
  logic [STEP_W-1:0] steps;
  logic              ovf_hold;
  logic [CNT_W:0]    rem_sh;
  logic [CNT_W:0]    rem_diff;
  logic              fits;

  // One quotient bit per cycle, restoring form.
  always_comb begin
    rem_sh   = {rem, quo[SUM_W-1]};
    rem_diff = rem_sh - {1'b0, divisor};
    fits     = (rem_sh >= {1'b0, divisor});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= DIV_IDLE;
    end else begin
      unique case (state)
        DIV_IDLE: begin
          if (start) begin
            state <= (count == '0) ? DIV_DONE : DIV_RUN;
          end
        end
        DIV_RUN: begin
          if (steps == STEP_W'(1)) begin
            state <= DIV_DONE;
          end
        end
        DIV_DONE: begin
          if (!result_stall) begin
            state <= DIV_IDLE;
          end
        end
        default: state <= DIV_IDLE;
      endcase
    end
  end

  // Datapath: the dividend shifts out as the quotient shifts in.
  always_ff @(posedge clk) begin
    if (state == DIV_IDLE && start) begin
      quo      <= (count == '0) ? '0 : sum;
      rem      <= '0;
      divisor  <= count;
      steps    <= STEP_W'(SUM_W);
      ovf_hold <= ovf;
    end else if (state == DIV_RUN) begin
      quo   <= {quo[SUM_W-2:0], fits};
      rem   <= fits ? rem_diff[CNT_W-1:0] : rem_sh[CNT_W-1:0];
      steps <= steps - 1'b1;
    end
  end

  assign ready        = (state == DIV_IDLE);
  assign result_valid = (state == DIV_DONE);

  always_comb begin
    result.mean_sq_distance = quo[MEAN_W-1:0];
    result.atoms_counted    = COUNT_W'(divisor);
    result.count_overflow   = ovf_hold;
  end

endmodule

>>> sv/masked_mean_squared_distance.sv
// Channel  | Handshake                   | Payload
// ---------+-----------------------------+-----------------------
// atom     | atom_valid / atom_stall     | atom   (atom_t)
// result   | result_valid / result_stall | result (result_t)
//
// Atoms are accepted one per cycle while the queue has room; qualifying ones are summed.
// A last atom hands its totals to a bit-serial divider that, unless the count is zero,
// shifts through all SUM_W (56) dividend bits; it then holds its result, and a further
// last atom waits until that result is taken. A four-entry queue between front and back
// keeps atoms flowing meanwhile. Reset (rst, synchronous) clears the valid flags, queue,
// totals and divider.
`include "masked_mean_squared_distance_macros.svh"

module masked_mean_squared_distance import mmsd_pkg::*; #(
  parameter int MAX_ATOMS  = 4096,
  parameter int COORD_BITS = 20
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    atom_valid,
  output logic    atom_stall,
  input  atom_t   atom,
  output logic    result_valid,
  input  logic    result_stall,
  output result_t result
);

  localparam int CNT_W   = $clog2(MAX_ATOMS + 1);
  localparam int DW      = COORD_BITS + 1;
  localparam int Q_WIDTH = 2 + 3 * DW;
  localparam int Q_DEPTH = 4;

  logic               push;
  atom_ctl_t          push_ctl;
  logic [DW-1:0]      push_dx;
  logic [DW-1:0]      push_dy;
  logic [DW-1:0]      push_dz;
  logic               q_full;
  logic               q_valid;
  logic               pop;
  logic [Q_WIDTH-1:0] q_in;
  logic [Q_WIDTH-1:0] q_out;
  atom_ctl_t          pop_ctl;
  logic [DW-1:0]      pop_dx;
  logic [DW-1:0]      pop_dy;
  logic [DW-1:0]      pop_dz;
  logic               div_ready;
  logic               div_start;
  logic [SUM_W-1:0]   div_sum;
  logic [CNT_W-1:0]   div_count;
  logic               div_ovf;

  // Front: takes atoms, flags the qualifying ones, forms absolute differences.
  mmsd_front #(
    .COORD_BITS(COORD_BITS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .atom_valid(atom_valid),
    .atom_stall(atom_stall),
    .atom      (atom),
    .q_full    (q_full),
    .push      (push),
    .push_ctl  (push_ctl),
    .push_dx   (push_dx),
    .push_dy   (push_dy),
    .push_dz   (push_dz)
  );

  assign q_in = {push_ctl, push_dx, push_dy, push_dz};

  mmsd_queue #(
    .WIDTH(Q_WIDTH),
    .DEPTH(Q_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_data(q_in),
    .full     (q_full),
    .pop      (pop),
    .pop_data (q_out),
    .nonempty (q_valid)
  );

  assign {pop_ctl, pop_dx, pop_dy, pop_dz} = q_out;

  // Back: squares and accumulates, then passes each molecule's totals on.
  mmsd_back #(
    .COORD_BITS(COORD_BITS),
    .MAX_ATOMS (MAX_ATOMS),
    .CNT_W     (CNT_W)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .q_valid  (q_valid),
    .pop      (pop),
    .pop_ctl  (pop_ctl),
    .pop_dx   (pop_dx),
    .pop_dy   (pop_dy),
    .pop_dz   (pop_dz),
    .div_ready(div_ready),
    .div_start(div_start),
    .div_sum  (div_sum),
    .div_count(div_count),
    .div_ovf  (div_ovf)
  );

  mmsd_div #(
    .CNT_W(CNT_W)
  ) u_div (
    .clk         (clk),
    .rst         (rst),
    .start       (div_start),
    .sum         (div_sum),
    .count       (div_count),
    .ovf         (div_ovf),
    .ready       (div_ready),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .result      (result)
  );

  // The front only holds off new atoms because the queue is full.
  `MMSD_ASSERT_SAME(a_stall_means_full, atom_stall, q_full)
  // A molecule handed to the divider keeps it busy in the next cycle.
  `MMSD_ASSERT_NEXT(a_div_busy_after_start, div_start, !div_ready)
  // A taken result is never shown twice.
  `MMSD_ASSERT_NEXT(a_result_once, result_valid && !result_stall, !result_valid)

endmodule

>>> tb/tb_masked_mean_squared_distance.sv
module tb_masked_mean_squared_distance;
  import mmsd_pkg::*;

  localparam int unsigned ATOM_LIMIT = 4096;
  localparam longint unsigned SUM_CEILING = (64'd1 << SUM_W) - 64'd1;
  localparam longint unsigned EXTREME_D2 = 64'd3298528591875;
  localparam int COORD_MIN = -524288;
  localparam int COORD_MAX = 524287;
  localparam int unsigned RANDOM_ATOMS = 900;
  localparam int unsigned HOLD_LEN = 400;
  localparam int unsigned WATCHDOG_LIMIT = 5000;
  localparam int unsigned DRAIN_CYCLES = 100;

  typedef struct {
    atom_t       a;
    int unsigned reps;
    bit          pinned;
    result_t     want;
  } stim_row_t;

  logic    clk = 1'b0;
  logic    rst = 1'b1;
  logic    atom_valid = 1'b0;
  logic    atom_stall;
  atom_t   atom = '0;
  logic    result_valid;
  logic    result_stall = 1'b0;
  result_t result;

  // Side band that travels with each offered item: a typed-in expectation.
  logic    pin_valid = 1'b0;
  result_t pin_result = '0;

  // Predictor state for the molecule being accumulated.
  longint unsigned acc_sum = 0;
  int unsigned     acc_count = 0;
  bit              acc_overflow = 1'b0;

  result_t     pending_results[$];
  stim_row_t   directed[$];
  int unsigned mismatches = 0;
  int unsigned atoms_taken = 0;
  int unsigned results_checked = 0;
  int unsigned overflow_results = 0;
  int unsigned quiet_cycles = 0;
  int unsigned hold_cycles = 0;
  bit          hold_request = 1'b0;
  bit          calm = 1'b0;
  bit          emits;
  result_t     predicted;
  result_t     next_want;

  masked_mean_squared_distance #(
    .MAX_ATOMS  (ATOM_LIMIT),
    .COORD_BITS (COORD_W)
  ) i_dut (
    .clk          (clk),
    .rst          (rst),
    .atom_valid   (atom_valid),
    .atom_stall   (atom_stall),
    .atom         (atom),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

  always #5 clk = ~clk;

  // Folds one atom into the running totals and closes the molecule on its last atom.
  function automatic void accumulate_atom(input atom_t a, output bit done, output result_t r);
    longint          dx;
    longint          dy;
    longint          dz;
    longint unsigned d2;
    longint unsigned mean;
    done = 1'b0;
    r = '0;
    if (a.active && a.heavy) begin
      if (acc_count >= ATOM_LIMIT) begin
        acc_overflow = 1'b1;
      end else begin
        dx = longint'($signed(a.ref_x)) - longint'($signed(a.conf_x));
        dy = longint'($signed(a.ref_y)) - longint'($signed(a.conf_y));
        dz = longint'($signed(a.ref_z)) - longint'($signed(a.conf_z));
        d2 = dx * dx + dy * dy + dz * dz;
        if (d2 > SUM_CEILING - acc_sum) acc_sum = SUM_CEILING;
        else acc_sum = acc_sum + d2;
        acc_count++;
      end
    end
    if (a.last_atom) begin
      mean = (acc_count != 0) ? acc_sum / acc_count : 64'd0;
      r.mean_sq_distance = mean[MEAN_W-1:0];
      r.atoms_counted = acc_count[COUNT_W-1:0];
      r.count_overflow = acc_overflow;
      done = 1'b1;
      acc_sum = 0;
      acc_count = 0;
      acc_overflow = 1'b0;
    end
  endfunction

  function automatic atom_t atom_of(input bit act, input bit hvy, input int rx, input int ry,
                                    input int rz, input int cx, input int cy, input int cz,
                                    input bit last);
    atom_t a;
    a.active = act;
    a.heavy = hvy;
    a.ref_x = rx[COORD_W-1:0];
    a.ref_y = ry[COORD_W-1:0];
    a.ref_z = rz[COORD_W-1:0];
    a.conf_x = cx[COORD_W-1:0];
    a.conf_y = cy[COORD_W-1:0];
    a.conf_z = cz[COORD_W-1:0];
    a.last_atom = last;
    return a;
  endfunction

  function automatic result_t outcome(input longint unsigned mean, input int unsigned count,
                                      input bit ovf);
    result_t r;
    r.mean_sq_distance = mean[MEAN_W-1:0];
    r.atoms_counted = count[COUNT_W-1:0];
    r.count_overflow = ovf;
    return r;
  endfunction

  function automatic stim_row_t pinned_row(input atom_t a, input int unsigned reps,
                                           input result_t want);
    stim_row_t s;
    s.a = a;
    s.reps = reps;
    s.pinned = 1'b1;
    s.want = want;
    return s;
  endfunction

  function automatic stim_row_t free_row(input atom_t a, input int unsigned reps);
    stim_row_t s;
    s.a = a;
    s.reps = reps;
    s.pinned = 1'b0;
    s.want = '0;
    return s;
  endfunction

  // A coordinate drawn from the full range, the extremes, or near the origin.
  function automatic logic [COORD_W-1:0] pick_coord();
    int unsigned shape;
    int          v;
    shape = $urandom_range(0, 9);
    if (shape < 5) return COORD_W'($urandom());
    if (shape < 7) begin
      case ($urandom_range(0, 4))
        0: v = COORD_MIN;
        1: v = COORD_MAX;
        2: v = 0;
        3: v = -1;
        default: v = 1;
      endcase
      return v[COORD_W-1:0];
    end
    v = int'($urandom_range(0, 2047)) - 1024;
    return v[COORD_W-1:0];
  endfunction

  // Conformer coordinates are either independent or a small offset from the reference.
  function automatic atom_t random_atom(input bit last, input bit noise);
    atom_t a;
    bit    close;
    a.active = noise ? ($urandom_range(0, 1) == 0) : ($urandom_range(0, 99) < 85);
    a.heavy = noise ? ~a.active : ($urandom_range(0, 99) < 85);
    a.ref_x = pick_coord();
    a.ref_y = pick_coord();
    a.ref_z = pick_coord();
    close = ($urandom_range(0, 1) == 1);
    a.conf_x = close ? a.ref_x + COORD_W'($urandom_range(0, 511) - 256) : pick_coord();
    a.conf_y = close ? a.ref_y + COORD_W'($urandom_range(0, 511) - 256) : pick_coord();
    a.conf_z = close ? a.ref_z + COORD_W'($urandom_range(0, 511) - 256) : pick_coord();
    a.last_atom = last;
    return a;
  endfunction

  task automatic note_mismatch(input string what, input logic [63:0] got,
                               input logic [63:0] want);
    mismatches++;
    if (mismatches <= 30)
      $display("MISMATCH at %0t: %s got %0d expected %0d", $time, what, got, want);
  endtask

  // Offers one item after a random gap, none while calm, and returns at the edge that accepts it.
  task automatic send_atom(input atom_t a, input bit pinned, input result_t want);
    while (!calm && $urandom_range(0, 99) < 36) begin
      atom_valid <= 1'b0;
      @(posedge clk);
    end
    atom_valid <= 1'b1;
    atom <= a;
    pin_valid <= pinned;
    pin_result <= want;
    do @(posedge clk); while (atom_stall);
  endtask

  // Result side: random stalls, a calm stretch, and one long hold-off on request.
  always @(posedge clk) begin
    if (rst) begin
      result_stall <= 1'b0;
    end else if (hold_cycles != 0) begin
      result_stall <= 1'b1;
      hold_cycles = hold_cycles - 1;
    end else if (hold_request) begin
      hold_request = 1'b0;
      hold_cycles = HOLD_LEN;
      result_stall <= 1'b1;
    end else if (calm) begin
      result_stall <= 1'b0;
    end else begin
      result_stall <= ($urandom_range(0, 99) < 36);
    end
  end

  // Predict on every accepted atom, check every accepted result, and watch for a hang.
  always @(posedge clk) begin
    if (!rst) begin
      quiet_cycles++;
      if (atom_valid && !atom_stall) begin
        quiet_cycles = 0;
        atoms_taken++;
        accumulate_atom(atom, emits, predicted);
        if (emits) pending_results.push_back(pin_valid ? pin_result : predicted);
      end
      if (result_valid && !result_stall) begin
        quiet_cycles = 0;
        if (pending_results.size() == 0) begin
          note_mismatch("result with none pending, mean", 64'(result.mean_sq_distance),
                        64'd0);
        end else begin
          next_want = pending_results.pop_front();
          results_checked++;
          if (next_want.count_overflow) overflow_results++;
          if (result.mean_sq_distance !== next_want.mean_sq_distance)
            note_mismatch("mean_sq_distance", 64'(result.mean_sq_distance),
                          64'(next_want.mean_sq_distance));
          if (result.atoms_counted !== next_want.atoms_counted)
            note_mismatch("atoms_counted", 64'(result.atoms_counted),
                          64'(next_want.atoms_counted));
          if (result.count_overflow !== next_want.count_overflow)
            note_mismatch("count_overflow", 64'(result.count_overflow),
                          64'(next_want.count_overflow));
        end
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("Timeout: no item moved for %0d cycles", WATCHDOG_LIMIT);
        $display("** masked_mean_squared_distance: FAILED **");
        $finish;
      end
    end
  end

  // Stimulus: directed table, then random molecules.
  initial begin
    int unsigned sent;
    int unsigned mol_len;
    int unsigned k;
    int unsigned molecules;
    bit          noise;
    bit          hold_done;
    bit          pause_done;

    sent = 0;
    molecules = 0;
    hold_done = 1'b0;
    pause_done = 1'b0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Empty molecules and the flag masking.
    directed.push_back(pinned_row(atom_of(0, 0, 0, 0, 0, 0, 0, 0, 1), 1, outcome(0, 0, 0)));
    directed.push_back(pinned_row(atom_of(1, 0, 100, 0, 0, 0, 0, 0, 1), 1, outcome(0, 0, 0)));
    directed.push_back(pinned_row(atom_of(0, 1, 100, 0, 0, 0, 0, 0, 1), 1, outcome(0, 0, 0)));
    directed.push_back(pinned_row(atom_of(1, 1, 1000, -2000, 3000, 1000, -2000, 3000, 1), 1,
                                  outcome(0, 1, 0)));
    // Widest possible distance in both directions.
    directed.push_back(pinned_row(atom_of(1, 1, COORD_MIN, COORD_MIN, COORD_MIN,
                                          COORD_MAX, COORD_MAX, COORD_MAX, 1), 1,
                                  outcome(EXTREME_D2, 1, 0)));
    directed.push_back(pinned_row(atom_of(1, 1, COORD_MAX, COORD_MAX, COORD_MAX,
                                          COORD_MIN, COORD_MIN, COORD_MIN, 1), 1,
                                  outcome(EXTREME_D2, 1, 0)));
    directed.push_back(pinned_row(atom_of(1, 1, 256, 0, 0, 0, 0, 0, 1), 1,
                                  outcome(65536, 1, 0)));
    // Two atoms averaging to half a unit squared.
    directed.push_back(free_row(atom_of(1, 1, 0, -256, 0, 0, 0, 0, 0), 1));
    directed.push_back(pinned_row(atom_of(1, 1, 5, 5, 5, 5, 5, 5, 1), 1,
                                  outcome(32768, 2, 0)));
    // A sum of one over three atoms truncates to zero.
    directed.push_back(free_row(atom_of(1, 1, 0, 0, 1, 0, 0, 0, 0), 1));
    directed.push_back(free_row(atom_of(1, 1, -7, -7, -7, -7, -7, -7, 0), 1));
    directed.push_back(pinned_row(atom_of(1, 1, 9, 9, 9, 9, 9, 9, 1), 1, outcome(0, 3, 0)));
    // Mixed signs, with a non-qualifying atom in between.
    directed.push_back(free_row(atom_of(1, 1, -300000, 250000, -1, 123456, -98765, 1, 0), 1));
    directed.push_back(free_row(atom_of(0, 1, COORD_MIN, 0, 0, COORD_MAX, 0, 0, 0), 1));
    directed.push_back(free_row(atom_of(1, 1, 77777, -1, 400000, -77777, 1, -400000, 1), 1));
    // A single-atom molecule right after a multi-atom one starts from clean totals.
    directed.push_back(pinned_row(atom_of(1, 1, 256, 0, 0, 0, 0, 0, 1), 1,
                                  outcome(65536, 1, 0)));

    foreach (directed[r]) begin
      for (k = 0; k < directed[r].reps; k++) send_atom(directed[r].a, directed[r].pinned,
                                                       directed[r].want);
      if (directed[r].a.last_atom) molecules++;
    end

    // Random molecules: mostly short, some long, a few with nothing qualifying.
    while (sent < RANDOM_ATOMS) begin
      calm = (sent >= 350 && sent < 500);
      if (!hold_done && sent >= 200) begin
        hold_request = 1'b1;
        hold_done = 1'b1;
      end
      if (!pause_done && sent >= 650) begin
        atom_valid <= 1'b0;
        @(posedge clk);
        while (pending_results.size() != 0) @(posedge clk);
        pause_done = 1'b1;
      end
      mol_len = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 10);
      noise = ($urandom_range(0, 9) == 0);
      for (k = 1; k <= mol_len; k++) begin
        send_atom(random_atom(k == mol_len, noise), 1'b0, '0);
        sent++;
      end
      molecules++;
    end
    atom_valid <= 1'b0;
    calm = 1'b0;
    @(posedge clk);

    // Let every expected result arrive, then watch for strays.
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (pending_results.size() != 0)
      note_mismatch("results never delivered", 64'(pending_results.size()), 64'd0);

    $display("Run covered %0d atoms in %0d molecules: extremes, empty molecules, noise.",
             atoms_taken, molecules);
    $display("Checked %0d results, %0d of them with count overflow, under stalls and a hold-off.",
             results_checked, overflow_results);
    if (mismatches == 0) begin
      $display("** masked_mean_squared_distance: PASSED **");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("** masked_mean_squared_distance: FAILED **");
    end
    $finish;
  end

endmodule
